/* hdl/mbrot_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Widths, constants and sequencer states shared by the escape-time block.
// ----------------------------------------------------------------------------
package mbrot_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;

  localparam int C_W   = COORD_WIDTH - 1;
  localparam int ZB_W  = FRAC_BITS + 3;
  localparam int N_W   = ((C_W > ZB_W) ? C_W : ZB_W) + 2;
  localparam int M_W   = N_W - 1;
  localparam int P_W   = 2 * M_W;
  localparam int SQ_W  = P_W - FRAC_BITS;
  localparam int MAG_W = SQ_W + 1;

  localparam int IN_DATA_W  = ((2 * C_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COUNT_WIDTH + 7) / 8) * 8;

  localparam logic [COUNT_WIDTH-1:0] ITER_LIMIT_RESET = COUNT_WIDTH'(1000);
  localparam logic [MAG_W-1:0]       FOUR = MAG_W'(4) << FRAC_BITS;
  localparam logic [M_W-1:0]         Z_MAX = M_W'(1) << (FRAC_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_XX,
    S_YY,
    S_XY,
    S_SUM0,
    S_SUM,
    S_ABS,
    S_NX,
    S_NY,
    S_MAG,
    S_LIMIT
  } state_t;

endpackage

/* hdl/mbrot_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned magnitude product with the result sign, registered on enable.
// ----------------------------------------------------------------------------
module mbrot_mul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [mbrot_pkg::M_W-1:0]  a,
  input  logic [mbrot_pkg::M_W-1:0]  b,
  input  logic                       neg_in,
  output logic [mbrot_pkg::P_W-1:0]  prod,
  output logic                       neg
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
      neg  <= neg_in;
    end
  end

endmodule

/* hdl/mandelbrot_escape_time_top.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Iterates z = z*z + c from z = 0 for one point and reports the escape index.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one point per beat: c_re and c_im, signed Q3.28.
//   m_* returns one result beat per point: iteration count, escape flag.
//   cfg_* writes the iteration limit; write it only while the block is idle.
// Timing:
//   One shared 32x32 multiplier does the five products of every iteration,
//   so an iteration steps through three z products, product drain, sum,
//   absolute value, two squares of the new z and the escape test.
//   A point that escapes loads its result from the escape test; a point
//   that reaches the limit loads its result from the limit step.
//   s_tready is high only while no point is in work, so the next point is
//   taken in the cycle after its predecessor's result is loaded at the earliest.
// Reset: rst clears the sequencer and output valid; the limit returns to 1000.
// Stall:
//   A finished result waits in the output register; the next point is
//   accepted meanwhile, and its own result holds until that slot frees.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [mbrot_pkg::IN_DATA_W-1:0]       s_tdata,   // c_re, c_im, zero pad
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mbrot_pkg::OUT_DATA_W-1:0]      m_tdata,   // iterations
  output logic [0:0]                            m_tuser,   // escaped
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mbrot_pkg::COUNT_WIDTH-1:0]     cfg_data   // iteration limit
);

  localparam int C_W  = mbrot_pkg::C_W;
  localparam int N_W  = mbrot_pkg::N_W;
  localparam int M_W  = mbrot_pkg::M_W;
  localparam int P_W  = mbrot_pkg::P_W;
  localparam int SQ_W = mbrot_pkg::SQ_W;
  localparam int CW   = mbrot_pkg::COUNT_WIDTH;
  localparam int FB   = mbrot_pkg::FRAC_BITS;
  localparam int OUT_DATA_W = mbrot_pkg::OUT_DATA_W;

  function automatic logic signed [N_W-1:0] floor_scale(input logic [P_W-1:0] p,
                                                         input logic n);
    logic signed [P_W:0] sp;
    sp = $signed({1'b0, p});
    if (n) begin
      sp = -sp;
    end
    return N_W'(sp >>> FB);
  endfunction

  mbrot_pkg::state_t state, state_next;

  logic [CW-1:0]         iter_limit;
  logic signed [N_W-1:0] cre, cim, xx, yy, xy, nx, ny;
  logic [M_W-1:0]        zx_abs, zy_abs, nx_abs, ny_abs;
  logic                  zx_neg, zy_neg;
  logic [SQ_W-1:0]       sqx;
  logic [CW-1:0]         count;
  logic                  out_valid, out_esc;
  logic [CW-1:0]         out_iter;

  logic                  mul_en, mul_neg_in, prod_neg;
  logic [M_W-1:0]        mul_a, mul_b;
  logic [P_W-1:0]        prod;
  logic signed [N_W-1:0] scaled;
  logic [mbrot_pkg::MAG_W-1:0] mag;
  logic                  escape, slot_free, last, load;
  logic [CW:0]           count_inc;
  logic signed [N_W-1:0] in_re, in_im;

  assign in_re = {{(N_W - C_W){s_tdata[C_W-1]}}, s_tdata[C_W-1:0]};
  assign in_im = {{(N_W - C_W){s_tdata[2*C_W-1]}}, s_tdata[2*C_W-1:C_W]};

  assign scaled    = floor_scale(prod, prod_neg);
  assign mag       = {1'b0, sqx} + {1'b0, prod[P_W-1:FB]};
  assign escape    = mag > mbrot_pkg::FOUR;
  assign slot_free = !out_valid || m_tready;
  assign count_inc = {1'b0, count} + (CW+1)'(1);
  assign last      = count_inc == {1'b0, iter_limit};

  assign s_tready  = state == mbrot_pkg::S_IDLE;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_DATA_W'(out_iter);
  assign m_tuser   = out_esc;

  mbrot_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .neg_in (mul_neg_in),
    .prod   (prod),
    .neg    (prod_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbrot_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = zx_abs;
    mul_b      = zy_abs;
    mul_neg_in = 1'b0;
    load       = 1'b0;
    case (state)
      mbrot_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (iter_limit == '0) ? mbrot_pkg::S_LIMIT : mbrot_pkg::S_XX;
        end
      end
      mbrot_pkg::S_XX: begin
        mul_en     = 1'b1;
        mul_a      = zx_abs;
        mul_b      = zx_abs;
        state_next = mbrot_pkg::S_YY;
      end
      mbrot_pkg::S_YY: begin
        mul_en     = 1'b1;
        mul_a      = zy_abs;
        mul_b      = zy_abs;
        state_next = mbrot_pkg::S_XY;
      end
      mbrot_pkg::S_XY: begin
        mul_en     = 1'b1;
        mul_neg_in = zx_neg ^ zy_neg;
        state_next = mbrot_pkg::S_SUM0;
      end
      mbrot_pkg::S_SUM0: state_next = mbrot_pkg::S_SUM;
      mbrot_pkg::S_SUM:  state_next = mbrot_pkg::S_ABS;
      mbrot_pkg::S_ABS:  state_next = mbrot_pkg::S_NX;
      mbrot_pkg::S_NX: begin
        mul_en     = 1'b1;
        mul_a      = nx_abs;
        mul_b      = nx_abs;
        state_next = mbrot_pkg::S_NY;
      end
      mbrot_pkg::S_NY: begin
        mul_en     = 1'b1;
        mul_a      = ny_abs;
        mul_b      = ny_abs;
        state_next = mbrot_pkg::S_MAG;
      end
      mbrot_pkg::S_MAG: begin
        if (escape) begin
          if (slot_free) begin
            load       = 1'b1;
            state_next = mbrot_pkg::S_IDLE;
          end
        end else if (last) begin
          state_next = mbrot_pkg::S_LIMIT;
        end else begin
          state_next = mbrot_pkg::S_XX;
        end
      end
      mbrot_pkg::S_LIMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = mbrot_pkg::S_IDLE;
        end
      end
      default: state_next = mbrot_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= mbrot_pkg::ITER_LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        iter_limit <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mbrot_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cre    <= in_re;
          cim    <= in_im;
          zx_abs <= '0;
          zy_abs <= '0;
          zx_neg <= 1'b0;
          zy_neg <= 1'b0;
          count  <= '0;
        end
      end
      mbrot_pkg::S_YY:   xx <= scaled;
      mbrot_pkg::S_XY:   yy <= scaled;
      mbrot_pkg::S_SUM0: xy <= scaled;
      mbrot_pkg::S_SUM: begin
        nx <= xx - yy + cre;
        ny <= (xy <<< 1) + cim;
      end
      mbrot_pkg::S_ABS: begin
        nx_abs <= M_W'(nx[N_W-1] ? -nx : nx);
        ny_abs <= M_W'(ny[N_W-1] ? -ny : ny);
      end
      mbrot_pkg::S_NY: sqx <= prod[P_W-1:FB];
      mbrot_pkg::S_MAG: begin
        if (escape) begin
          if (slot_free) begin
            out_iter <= count;
            out_esc  <= 1'b1;
          end
        end else begin
          zx_abs <= nx_abs;
          zy_abs <= ny_abs;
          zx_neg <= nx[N_W-1];
          zy_neg <= ny[N_W-1];
          count  <= count_inc[CW-1:0];
        end
      end
      mbrot_pkg::S_LIMIT: begin
        if (slot_free) begin
          out_iter <= iter_limit;
          out_esc  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == mbrot_pkg::S_XX || state == mbrot_pkg::S_LIMIT))
    else $error("accepted point did not start the sequencer");

  a_sum_order: assert property (@(posedge clk) disable iff (rst)
    (state == mbrot_pkg::S_SUM) |-> ($past(state) == mbrot_pkg::S_SUM0))
    else $error("sum step entered out of order");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == mbrot_pkg::S_MAG || $past(state) == mbrot_pkg::S_LIMIT))
    else $error("result beat raised outside a finishing step");

  a_z_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mbrot_pkg::S_XX) |-> (zx_abs <= mbrot_pkg::Z_MAX && zy_abs <= mbrot_pkg::Z_MAX))
    else $error("z magnitude out of range before escape test");

endmodule

/* verif/mandelbrot_escape_time_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit testbench
// Sends complex points through the stream port, across several iteration
// limits, with typed expectations for extremes and boundary cases and an
// iteration-accurate fixed-point escape predictor for everything else. Results
// are scoreboarded in order under random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top_test;

  localparam int  COUNT_WIDTH = mbrot_pkg::COUNT_WIDTH;
  localparam int  C_W         = mbrot_pkg::C_W;
  localparam int  FRAC_BITS   = mbrot_pkg::FRAC_BITS;
  localparam int  IN_DATA_W   = mbrot_pkg::IN_DATA_W;
  localparam int  OUT_DATA_W  = mbrot_pkg::OUT_DATA_W;

  localparam int  QUIET_LIMIT = 2_500_000;
  localparam int  LONG_HOLD   = 2000;
  localparam int  PHASE_ITEMS = 100;
  localparam logic TYPED   = 1'b1;
  localparam logic PREDICT = 1'b0;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] iters;
    logic                   escaped;
  } esc_result_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] lim;
    logic [C_W-1:0]         re;
    logic [C_W-1:0]         im;
    logic                   chk;
    logic [COUNT_WIDTH-1:0] iters;
    logic                   escaped;
  } stim_row_t;

  localparam stim_row_t DIRECTED [24] = '{
    '{16'd1000,  31'h00000000, 31'h00000000, TYPED,   16'd1000,  1'b0},
    '{16'd1000,  31'h3FFFFFFF, 31'h00000000, TYPED,   16'd0,     1'b1},
    '{16'd1000,  31'h40000000, 31'h00000000, TYPED,   16'd0,     1'b1},
    '{16'd1000,  31'h00000000, 31'h3FFFFFFF, TYPED,   16'd0,     1'b1},
    '{16'd1000,  31'h00000000, 31'h40000000, TYPED,   16'd0,     1'b1},
    '{16'd1000,  31'h3FFFFFFF, 31'h3FFFFFFF, TYPED,   16'd0,     1'b1},
    '{16'd1000,  31'h40000000, 31'h40000000, TYPED,   16'd0,     1'b1},
    '{16'd1000,  31'h20000000, 31'h00000000, TYPED,   16'd1,     1'b1},
    '{16'd1000,  31'h60000000, 31'h00000000, TYPED,   16'd1000,  1'b0},
    '{16'd1000,  31'h00000000, 31'h20000000, TYPED,   16'd1,     1'b1},
    '{16'd1000,  31'h00000000, 31'h60000000, TYPED,   16'd1,     1'b1},
    '{16'd1000,  31'h74000000, 31'h0199999A, PREDICT, 16'd0,     1'b0},
    '{16'd1000,  31'h04CCCCCD, 31'h08000000, PREDICT, 16'd0,     1'b0},
    '{16'd1000,  31'h78000000, 31'h78000000, PREDICT, 16'd0,     1'b0},
    '{16'd1000,  31'h00000001, 31'h7FFFFFFF, PREDICT, 16'd0,     1'b0},
    '{16'd0,     31'h00000000, 31'h00000000, TYPED,   16'd0,     1'b0},
    '{16'd0,     31'h3FFFFFFF, 31'h40000000, TYPED,   16'd0,     1'b0},
    '{16'd1,     31'h00000000, 31'h00000000, TYPED,   16'd1,     1'b0},
    '{16'd1,     31'h3FFFFFFF, 31'h00000000, TYPED,   16'd0,     1'b1},
    '{16'd1,     31'h10000000, 31'h00000000, TYPED,   16'd1,     1'b0},
    '{16'd65535, 31'h10000000, 31'h00000000, TYPED,   16'd2,     1'b1},
    '{16'd65535, 31'h00000000, 31'h00000000, TYPED,   16'd65535, 1'b0},
    '{16'd65535, 31'h08000000, 31'h08000000, PREDICT, 16'd0,     1'b0},
    '{16'd1000,  31'h40000000, 31'h3FFFFFFF, TYPED,   16'd0,     1'b1}
  };

  localparam logic [COUNT_WIDTH-1:0] PHASE_LIM [6] = '{
    16'd64, 16'd1, 16'd0, 16'd200, 16'd16, 16'd0
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [0:0]             m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [COUNT_WIDTH-1:0] cfg_data;

  esc_result_t            pending_results[$];
  esc_result_t            got_want;
  logic [COUNT_WIDTH-1:0] limit_q;
  int                     errors = 0;
  int                     tx_idle;
  int                     rx_idle;
  int                     quiet_cycles = 0;
  int                     hold_reqs;

  mandelbrot_escape_time_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    return p[FRAC_BITS +: 64];
  endfunction

  function automatic esc_result_t escape_count(input logic signed [C_W-1:0] cre_in,
                                               input logic signed [C_W-1:0] cim_in,
                                               input logic [COUNT_WIDTH-1:0] lim);
    logic signed [63:0] cre, cim, zx, zy, xx, yy, xy2, nx, ny, mag;
    logic [63:0]        four;
    esc_result_t        res;
    int unsigned        i;
    bit                 done;
    cre  = 64'(cre_in);
    cim  = 64'(cim_in);
    zx   = '0;
    zy   = '0;
    four = 64'd4 << FRAC_BITS;
    res  = '{lim, 1'b0};
    done = 1'b0;
    for (i = 0; i < lim && !done; i++) begin
      xx  = fx_mul(zx, zx);
      yy  = fx_mul(zy, zy);
      xy2 = fx_mul(zx, zy) <<< 1;
      nx  = xx - yy + cre;
      ny  = xy2 + cim;
      mag = fx_mul(nx, nx) + fx_mul(ny, ny);
      if ($unsigned(mag) > four) begin
        res  = '{i[COUNT_WIDTH-1:0], 1'b1};
        done = 1'b1;
      end else begin
        zx = nx;
        zy = ny;
      end
    end
    return res;
  endfunction

  task automatic send_point(input logic [C_W-1:0] re, input logic [C_W-1:0] im,
                            input esc_result_t want);
    s_tdata  <= {{(IN_DATA_W - 2 * C_W){1'b0}}, im, re};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(want);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_WIDTH-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_q    = v;
  endtask

  // receiver: random backpressure, plus one long hold on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        m_tready <= 1'b0;
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat iterations=%0d escaped=%0d",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        got_want = pending_results.pop_front();
        if (m_tdata[COUNT_WIDTH-1:0] != got_want.iters) begin
          $display("%0t: iterations mismatch expected=%0d actual=%0d",
                   $time, got_want.iters, m_tdata[COUNT_WIDTH-1:0]);
          errors++;
        end
        if (m_tuser[0] != got_want.escaped) begin
          $display("%0t: escaped mismatch expected=%0d actual=%0d",
                   $time, got_want.escaped, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t              row;
    esc_result_t            want;
    logic [COUNT_WIDTH-1:0] lim;
    logic [C_W-1:0]         re, im;
    int                     p, n, coord;
    hold_reqs    = 0;
    tx_idle      = 8;
    rx_idle      = 84;
    limit_q      = mbrot_pkg::ITER_LIMIT_RESET;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < 24; n++) begin
      row = DIRECTED[n];
      if (row.lim != limit_q) begin
        wait_idle();
        write_limit(row.lim);
      end
      if (row.chk == TYPED)
        want = '{row.iters, row.escaped};
      else
        want = escape_count(row.re, row.im, limit_q);
      send_point(row.re, row.im, want);
    end

    for (p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          tx_idle = 8;
          rx_idle = 84;
        end
        1: begin
          tx_idle = 84;
          rx_idle = 8;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      lim = (p == 5) ? COUNT_WIDTH'($urandom_range(2, 500)) : PHASE_LIM[p];
      wait_idle();
      write_limit(lim);
      if (p == 4) hold_reqs++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) wait_idle();
        if ($urandom_range(0, 3) == 0) begin
          re = C_W'($urandom());
          im = C_W'($urandom());
        end else begin
          // bias toward the set boundary: re in [-2.25, 0.75], im in [-1.5, 1.5]
          coord = int'($urandom_range(0, 805306368)) - 603979776;
          re    = coord[C_W-1:0];
          coord = int'($urandom_range(0, 805306368)) - 402653184;
          im    = coord[C_W-1:0];
        end
        send_point(re, im, escape_count(re, im, limit_q));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
